// ===== design/sss2_pkg.sv =====
// sss2_pkg: shared types and constants of the second-order state-space step unit
// register index codes and the sample counter width
// no dependencies
package sss2_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int COUNT_WIDTH     = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        IDX_A11    = 3'd0,
        IDX_A12    = 3'd1,
        IDX_A21    = 3'd2,
        IDX_A22    = 3'd3,
        IDX_B_PAIR = 3'd4,
        IDX_C_PAIR = 3'd5,
        IDX_D_GAIN = 3'd6
    } cfg_index_t;

endpackage

// ===== design/sss2_cfg_regs.sv =====
// sss2_cfg_regs: coefficient register file of the state-space step unit
// decodes the write port and splits the packed b and c rows into signed halves
// depends on sss2_pkg
module sss2_cfg_regs #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [sss2_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [2*COEF_WIDTH-1:0]                 cfg_data,
    output logic signed [COEF_WIDTH-1:0]            a11,
    output logic signed [COEF_WIDTH-1:0]            a12,
    output logic signed [COEF_WIDTH-1:0]            a21,
    output logic signed [COEF_WIDTH-1:0]            a22,
    output logic signed [COEF_WIDTH-1:0]            b1,
    output logic signed [COEF_WIDTH-1:0]            b2,
    output logic signed [COEF_WIDTH-1:0]            c1,
    output logic signed [COEF_WIDTH-1:0]            c2,
    output logic signed [COEF_WIDTH-1:0]            d_gain
);

    logic [COEF_WIDTH-1:0]   a11_reg;
    logic [COEF_WIDTH-1:0]   a12_reg;
    logic [COEF_WIDTH-1:0]   a21_reg;
    logic [COEF_WIDTH-1:0]   a22_reg;
    logic [2*COEF_WIDTH-1:0] b_pair_reg;
    logic [2*COEF_WIDTH-1:0] c_pair_reg;
    logic [COEF_WIDTH-1:0]   d_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a11_reg    <= '0;
            a12_reg    <= '0;
            a21_reg    <= '0;
            a22_reg    <= '0;
            b_pair_reg <= '0;
            c_pair_reg <= '0;
            d_gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (sss2_pkg::cfg_index_t'(cfg_index))
                sss2_pkg::IDX_A11:    a11_reg    <= cfg_data[COEF_WIDTH-1:0];
                sss2_pkg::IDX_A12:    a12_reg    <= cfg_data[COEF_WIDTH-1:0];
                sss2_pkg::IDX_A21:    a21_reg    <= cfg_data[COEF_WIDTH-1:0];
                sss2_pkg::IDX_A22:    a22_reg    <= cfg_data[COEF_WIDTH-1:0];
                sss2_pkg::IDX_B_PAIR: b_pair_reg <= cfg_data;
                sss2_pkg::IDX_C_PAIR: c_pair_reg <= cfg_data;
                sss2_pkg::IDX_D_GAIN: d_gain_reg <= cfg_data[COEF_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign a11    = $signed(a11_reg);
    assign a12    = $signed(a12_reg);
    assign a21    = $signed(a21_reg);
    assign a22    = $signed(a22_reg);
    assign b1     = $signed(b_pair_reg[COEF_WIDTH-1:0]);
    assign b2     = $signed(b_pair_reg[2*COEF_WIDTH-1:COEF_WIDTH]);
    assign c1     = $signed(c_pair_reg[COEF_WIDTH-1:0]);
    assign c2     = $signed(c_pair_reg[2*COEF_WIDTH-1:COEF_WIDTH]);
    assign d_gain = $signed(d_gain_reg);

endmodule

// ===== design/sss2_row.sv =====
// sss2_row: one row of the state-space step, k0*x0 + k1*x1 + k2*u
// rounds half up to the sample format and clamps to the signed sample range
// no dependencies
module sss2_row #(
    parameter int COEF_WIDTH   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic signed [COEF_WIDTH-1:0]   k0,
    input  logic signed [COEF_WIDTH-1:0]   k1,
    input  logic signed [COEF_WIDTH-1:0]   k2,
    input  logic signed [SAMPLE_WIDTH-1:0] x0,
    input  logic signed [SAMPLE_WIDTH-1:0] x1,
    input  logic signed [SAMPLE_WIDTH-1:0] u,
    output logic signed [SAMPLE_WIDTH-1:0] result,
    output logic                           clamped
);

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC   = COEF_WIDTH - 4;
    localparam int RES_W  = SUM_W - FRAC;

    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (FRAC - 1);
    localparam logic signed [RES_W-1:0] MAX_VAL =
        RES_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [RES_W-1:0] MIN_VAL = -MAX_VAL - RES_W'(1);

    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [SUM_W-1:0]  sum;
    logic signed [RES_W-1:0]  scaled;

    assign p0     = PROD_W'(k0) * PROD_W'(x0);
    assign p1     = PROD_W'(k1) * PROD_W'(x1);
    assign p2     = PROD_W'(k2) * PROD_W'(u);
    assign sum    = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + HALF_LSB;
    assign scaled = $signed(sum[SUM_W-1:FRAC]);

    always_comb
    begin
        clamped = 1'b0;
        result  = scaled[SAMPLE_WIDTH-1:0];
        if (scaled > MAX_VAL)
        begin
            clamped = 1'b1;
            result  = MAX_VAL[SAMPLE_WIDTH-1:0];
        end
        else if (scaled < MIN_VAL)
        begin
            clamped = 1'b1;
            result  = MIN_VAL[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// ===== design/state_space_step_2x1_unit.sv =====
// state_space_step_2x1_unit: second-order state-space system, one input and one output
// top level with input register, three row units, state and result register
// depends on sss2_pkg, sss2_cfg_regs, sss2_row
//
// usage
// - input channel: u_sample with in_valid; a word is taken at a clock edge with
//   in_valid high and in_stall low
// - output channel: x0_now, x1_now, y_out, sample_index, overflow with out_valid;
//   a word leaves at an edge with out_valid high and out_stall low
// - coefficients are loaded through cfg_we, cfg_index, cfg_data while idle
// - path: a taken word moves from the input register to the result register, which drives the output
// - throughput: one word per cycle while the result is not stalled; the state update is one
//   multiply-add pass between the input register and the result register
// - a stalled result holds; the input register still takes one more word,
//   then in_stall rises until the result is taken
// - reset clears coefficients, state, sample counter and both valid flags
module state_space_step_2x1_unit #(
    parameter int COEF_WIDTH   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sss2_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [2*COEF_WIDTH-1:0]              cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       u_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       x0_now,
    output logic signed [SAMPLE_WIDTH-1:0]       x1_now,
    output logic signed [SAMPLE_WIDTH-1:0]       y_out,
    output logic [sss2_pkg::COUNT_WIDTH-1:0]     sample_index,
    output logic                                 overflow
);

    logic signed [COEF_WIDTH-1:0] a11;
    logic signed [COEF_WIDTH-1:0] a12;
    logic signed [COEF_WIDTH-1:0] a21;
    logic signed [COEF_WIDTH-1:0] a22;
    logic signed [COEF_WIDTH-1:0] b1;
    logic signed [COEF_WIDTH-1:0] b2;
    logic signed [COEF_WIDTH-1:0] c1;
    logic signed [COEF_WIDTH-1:0] c2;
    logic signed [COEF_WIDTH-1:0] d_gain;

    logic                                 in_full_reg;
    logic                                 in_full_next;
    logic signed [SAMPLE_WIDTH-1:0]       u_reg;
    logic signed [SAMPLE_WIDTH-1:0]       state_x0_reg;
    logic signed [SAMPLE_WIDTH-1:0]       state_x1_reg;
    logic [sss2_pkg::COUNT_WIDTH-1:0]     count_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0]       x0_now_reg;
    logic signed [SAMPLE_WIDTH-1:0]       x1_now_reg;
    logic signed [SAMPLE_WIDTH-1:0]       y_out_reg;
    logic [sss2_pkg::COUNT_WIDTH-1:0]     sample_index_reg;
    logic                                 overflow_reg;

    logic                                 accept_in;
    logic                                 advance;
    logic signed [SAMPLE_WIDTH-1:0]       y_val;
    logic signed [SAMPLE_WIDTH-1:0]       n0_val;
    logic signed [SAMPLE_WIDTH-1:0]       n1_val;
    logic                                 y_clamp;
    logic                                 n0_clamp;
    logic                                 n1_clamp;

    sss2_cfg_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .a11       (a11),
        .a12       (a12),
        .a21       (a21),
        .a22       (a22),
        .b1        (b1),
        .b2        (b2),
        .c1        (c1),
        .c2        (c2),
        .d_gain    (d_gain)
    );

    // output row
    sss2_row #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_row_y (
        .k0      (c1),
        .k1      (c2),
        .k2      (d_gain),
        .x0      (state_x0_reg),
        .x1      (state_x1_reg),
        .u       (u_reg),
        .result  (y_val),
        .clamped (y_clamp)
    );

    // state update rows
    sss2_row #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_row_x0 (
        .k0      (a11),
        .k1      (a12),
        .k2      (b1),
        .x0      (state_x0_reg),
        .x1      (state_x1_reg),
        .u       (u_reg),
        .result  (n0_val),
        .clamped (n0_clamp)
    );

    sss2_row #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_row_x1 (
        .k0      (a21),
        .k1      (a22),
        .k2      (b2),
        .x0      (state_x0_reg),
        .x1      (state_x1_reg),
        .u       (u_reg),
        .result  (n1_val),
        .clamped (n1_clamp)
    );

    assign advance        = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_full_reg && !advance;
    assign accept_in      = in_valid && !in_stall;
    assign in_full_next   = accept_in || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            state_x0_reg  <= '0;
            state_x1_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_x0_reg <= n0_val;
                state_x1_reg <= n1_val;
                count_reg    <= count_reg + sss2_pkg::COUNT_WIDTH'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            u_reg <= u_sample;
        end
        if (advance)
        begin
            x0_now_reg       <= state_x0_reg;
            x1_now_reg       <= state_x1_reg;
            y_out_reg        <= y_val;
            sample_index_reg <= count_reg;
            overflow_reg     <= y_clamp || n0_clamp || n1_clamp;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x0_now       = x0_now_reg;
    assign x1_now       = x1_now_reg;
    assign y_out        = y_out_reg;
    assign sample_index = sample_index_reg;
    assign overflow     = overflow_reg;

    // input stalls only behind a full input register and a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    // counter steps once per word moved to the result register
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (count_reg == $past(count_reg) + sss2_pkg::COUNT_WIDTH'(1)))
        else $error("sample counter did not step");

    // state changes only when a word moves on
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(state_x0_reg) && $stable(state_x1_reg)
                      && $stable(count_reg)))
        else $error("state changed without a word");

    // a finished result is shown in the cycle after it moved on
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && sample_index_reg == $past(count_reg)))
        else $error("result not shown after moving on");

endmodule

// ===== dv/state_space_step_2x1_unit_tb.sv =====
// state_space_step_2x1_unit_tb: self-checking testbench of the second-order state-space step unit
// directed table then random phases, every result word checked against typed values or an in-bench predictor
// depends on sss2_pkg and state_space_step_2x1_unit
module state_space_step_2x1_unit_tb;

    localparam int CW = 16;
    localparam int SW = 16;
    localparam int FRAC_BITS = CW - 4;
    localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);
    localparam longint SAMPLE_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam logic [sss2_pkg::CFG_INDEX_WIDTH-1:0] IDX_UNUSED = 3'd7;
    localparam int WORD_TARGET = 520;

    typedef struct packed {
        logic signed [SW-1:0]             x0;
        logic signed [SW-1:0]             x1;
        logic signed [SW-1:0]             y;
        logic [sss2_pkg::COUNT_WIDTH-1:0] idx;
        logic                             ovf;
    } ss_word_t;

    typedef struct packed {
        logic                                 is_cfg;
        logic [sss2_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [2*CW-1:0]                      data;
        logic [SW-1:0]                        u;
        logic                                 typed;
        ss_word_t                             want;
    } plan_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we;
    logic [sss2_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [2*CW-1:0]                      cfg_data;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [SW-1:0]                 u_sample;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [SW-1:0]                 x0_now;
    logic signed [SW-1:0]                 x1_now;
    logic signed [SW-1:0]                 y_out;
    logic [sss2_pkg::COUNT_WIDTH-1:0]     sample_index;
    logic                                 overflow;

    // predictor copy of coefficients and state
    logic signed [CW-1:0]             coef_a11, coef_a12, coef_a21, coef_a22, coef_d;
    logic [2*CW-1:0]                  coef_b, coef_c;
    logic signed [SW-1:0]             st_x0, st_x1;
    logic [sss2_pkg::COUNT_WIDTH-1:0] st_count;

    ss_word_t expected_words[$];
    int       fail_count = 0;
    int       words_total = 0;

    state_space_step_2x1_unit #(
        .COEF_WIDTH   (CW),
        .SAMPLE_WIDTH (SW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .u_sample     (u_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .x0_now       (x0_now),
        .x1_now       (x1_now),
        .y_out        (y_out),
        .sample_index (sample_index),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // top bit flags a clamp
    function automatic logic [SW:0] round_clamp(longint acc);
        longint r;
        r = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (r > SAMPLE_MAX)
            return {1'b1, 1'b0, {(SW-1){1'b1}}};
        if (r < SAMPLE_MIN)
            return {1'b1, 1'b1, {(SW-1){1'b0}}};
        return {1'b0, r[SW-1:0]};
    endfunction

    function automatic ss_word_t predict_word(logic signed [SW-1:0] u);
        ss_word_t             w;
        logic signed [CW-1:0] b1, b2, c1, c2;
        logic [SW:0]          y_r, n0_r, n1_r;
        b1 = coef_b[CW-1:0];
        b2 = coef_b[2*CW-1:CW];
        c1 = coef_c[CW-1:0];
        c2 = coef_c[2*CW-1:CW];
        y_r  = round_clamp(longint'(c1) * longint'(st_x0) + longint'(c2) * longint'(st_x1)
                           + longint'(coef_d) * longint'(u));
        n0_r = round_clamp(longint'(coef_a11) * longint'(st_x0)
                           + longint'(coef_a12) * longint'(st_x1) + longint'(b1) * longint'(u));
        n1_r = round_clamp(longint'(coef_a21) * longint'(st_x0)
                           + longint'(coef_a22) * longint'(st_x1) + longint'(b2) * longint'(u));
        w.x0  = st_x0;
        w.x1  = st_x1;
        w.y   = y_r[SW-1:0];
        w.idx = st_count;
        w.ovf = y_r[SW] | n0_r[SW] | n1_r[SW];
        st_x0 = n0_r[SW-1:0];
        st_x1 = n1_r[SW-1:0];
        st_count = st_count + sss2_pkg::COUNT_WIDTH'(1);
        return w;
    endfunction

    function automatic plan_row_t cfg_row(logic [sss2_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                          logic [2*CW-1:0] data);
        plan_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.data    = data;
        return r;
    endfunction

    function automatic plan_row_t word_row(logic [SW-1:0] u);
        plan_row_t r;
        r = '0;
        r.u = u;
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic [SW-1:0] u, logic [SW-1:0] x0,
                                            logic [SW-1:0] x1, logic [SW-1:0] y,
                                            logic [sss2_pkg::COUNT_WIDTH-1:0] n, logic ovf);
        plan_row_t r;
        r = '0;
        r.u     = u;
        r.typed = 1'b1;
        r.want  = '{x0: x0, x1: x1, y: y, idx: n, ovf: ovf};
        return r;
    endfunction

    // phase 0 all max, phase 1 all min, later phases mixed, last phase small only
    function automatic logic [CW-1:0] pick_coef(int phase);
        if (phase == 0)
            return {1'b0, {(CW-1){1'b1}}};
        if (phase == 1)
            return {1'b1, {(CW-1){1'b0}}};
        if (phase >= 8)
            return CW'($urandom_range(0, 3072) - 1536);
        case ($urandom_range(0, 5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return '0;
            3: return CW'($urandom());
            default: return CW'($urandom_range(0, 6144) - 3072);
        endcase
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2, 3: return SW'($urandom_range(0, 512) - 256);
            default: return SW'($urandom());
        endcase
    endfunction

    task automatic check_field(string name, logic [SW-1:0] want, logic [SW-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // offer one word, hold it until taken, then predict its result
    task automatic send_word(logic [SW-1:0] u, logic typed, ss_word_t want);
        ss_word_t w;
        in_valid <= 1'b1;
        u_sample <= u;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w = predict_word(u);
        words_total++;
        expected_words.push_back(typed ? want : w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [sss2_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [2*CW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            sss2_pkg::IDX_A11:    coef_a11 = data[CW-1:0];
            sss2_pkg::IDX_A12:    coef_a12 = data[CW-1:0];
            sss2_pkg::IDX_A21:    coef_a21 = data[CW-1:0];
            sss2_pkg::IDX_A22:    coef_a22 = data[CW-1:0];
            sss2_pkg::IDX_B_PAIR: coef_b   = data;
            sss2_pkg::IDX_C_PAIR: coef_c   = data;
            sss2_pkg::IDX_D_GAIN: coef_d   = data[CW-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        ss_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                fail_count++;
                $error("result word with nothing expected");
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("x0_now", want.x0, x0_now);
                check_field("x1_now", want.x1, x1_now);
                check_field("y_out", want.y, y_out);
                check_field("sample_index", want.idx, sample_index);
                check_field("overflow", {{(SW-1){1'b0}}, want.ovf}, {{(SW-1){1'b0}}, overflow});
            end
        end
    end

    // receiver: stretches of random stall density, every sixteenth a long hold
    initial
    begin : receiver
        int stretch;
        int mode;
        int n;
        stretch = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch++;
            if (stretch % 16 == 0)
            begin
                repeat (80)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                n = $urandom_range(1, 40);
                repeat (n)
                begin
                    @(posedge clk);
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t plan[$];
        int        p;
        int        sent;
        int        burst;
        int        gap;
        cfg_we    <= 1'b0;
        cfg_index <= sss2_pkg::IDX_A11;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        u_sample  <= '0;
        coef_a11 = '0;
        coef_a12 = '0;
        coef_a21 = '0;
        coef_a22 = '0;
        coef_b   = '0;
        coef_c   = '0;
        coef_d   = '0;
        st_x0    = '0;
        st_x1    = '0;
        st_count = '0;

        // zero coefficients, clamping gain, round half up, ignored writes
        plan.push_back(typed_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'd0, 1'b0));
        plan.push_back(typed_row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0));
        plan.push_back(cfg_row(sss2_pkg::IDX_D_GAIN, 32'hABCD_7FFF));
        plan.push_back(typed_row(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'd2, 1'b1));
        plan.push_back(typed_row(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'd3, 1'b1));
        plan.push_back(cfg_row(sss2_pkg::IDX_D_GAIN, 32'h0000_8000));
        plan.push_back(typed_row(16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'd4, 1'b1));
        plan.push_back(typed_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd5, 1'b0));
        plan.push_back(cfg_row(sss2_pkg::IDX_D_GAIN, 32'h0000_0800));
        plan.push_back(typed_row(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'd6, 1'b0));
        plan.push_back(typed_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'd7, 1'b0));
        plan.push_back(typed_row(16'h0003, 16'h0000, 16'h0000, 16'h0002, 16'd8, 1'b0));
        plan.push_back(typed_row(16'hFFFD, 16'h0000, 16'h0000, 16'hFFFF, 16'd9, 1'b0));
        plan.push_back(cfg_row(IDX_UNUSED, 32'h0000_1000));
        plan.push_back(typed_row(16'h0003, 16'h0000, 16'h0000, 16'h0002, 16'd10, 1'b0));
        plan.push_back(cfg_row(sss2_pkg::IDX_B_PAIR, 32'h7FFF_8000));
        plan.push_back(word_row(16'h7FFF));
        plan.push_back(word_row(16'h0100));
        plan.push_back(cfg_row(sss2_pkg::IDX_A11, 32'hFFFF_1000));
        plan.push_back(cfg_row(sss2_pkg::IDX_A12, 32'h0000_8000));
        plan.push_back(cfg_row(sss2_pkg::IDX_A21, 32'h5A5A_7FFF));
        plan.push_back(cfg_row(sss2_pkg::IDX_A22, 32'h0000_F000));
        plan.push_back(cfg_row(sss2_pkg::IDX_C_PAIR, 32'h8000_7FFF));
        plan.push_back(word_row(16'h8000));
        plan.push_back(word_row(16'h1234));
        plan.push_back(word_row(16'h0000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].data);
            end
            else
                send_word(plan[i].u, plan[i].typed, plan[i].want);
        end

        // random phases, then a closing stream up to the word target
        for (p = 0; p <= 8; p++)
        begin
            wait_idle();
            write_reg(sss2_pkg::IDX_A11, {CW'($urandom()), pick_coef(p)});
            write_reg(sss2_pkg::IDX_A12, {CW'($urandom()), pick_coef(p)});
            write_reg(sss2_pkg::IDX_A21, {CW'($urandom()), pick_coef(p)});
            write_reg(sss2_pkg::IDX_A22, {CW'($urandom()), pick_coef(p)});
            write_reg(sss2_pkg::IDX_B_PAIR, {pick_coef(p), pick_coef(p)});
            write_reg(sss2_pkg::IDX_C_PAIR, {pick_coef(p), pick_coef(p)});
            write_reg(sss2_pkg::IDX_D_GAIN, {CW'($urandom()), pick_coef(p)});
            write_reg(IDX_UNUSED, $urandom());
            sent = 0;
            while ((p < 8 && sent < 60) || (p == 8 && words_total < WORD_TARGET))
            begin
                burst = $urandom_range(1, 24);
                if (p == 8)
                    gap = $urandom_range(0, 1);
                else if (p % 3 == 2)
                    gap = 0;
                else
                    gap = $urandom_range(0, 6);
                repeat (burst)
                begin
                    send_word(pick_sample(), 1'b0, '0);
                    sent++;
                end
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sss2_pkg.sv
design/sss2_cfg_regs.sv
design/sss2_row.sv
design/state_space_step_2x1_unit.sv
dv/state_space_step_2x1_unit_tb.sv
